### rtl/cau_pkg.sv
// shared types, constants and arithmetic helpers for the complex arithmetic unit
`default_nettype none
package cau_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int SW   = DATA_WIDTH + 1;             // add/sub width
    localparam int PW   = 2 * DATA_WIDTH;             // product width
    localparam int MW   = PW + 1;                     // magnitude width at rounding
    localparam int QW   = DATA_WIDTH + FRAC_BITS + 1; // quotient bits, one guard bit
    localparam int HALF = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]           op;
        logic                 dz;
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] si;
        logic signed [PW-1:0] prr;
        logic signed [PW-1:0] pii;
        logic signed [PW-1:0] pri;
        logic signed [PW-1:0] pir;
        logic [PW-2:0]        sqr;
        logic [PW-2:0]        sqi;
    } t_entry;

    // one divider stage
    typedef struct packed {
        logic [1:0]           op;
        logic                 dz;
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] si;
        logic                 nr;
        logic                 ni;
        logic [PW-1:0]        mr;
        logic [PW-1:0]        mi;
        logic                 capr;
        logic                 capi;
        logic [PW-1:0]        den;
        logic [PW-1:0]        remr;
        logic [PW-1:0]        remi;
        logic [QW-1:0]        qr;
        logic [QW-1:0]        qi;
    } t_ds;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } t_sat;

    // sign and magnitude to clamped signed value
    function automatic t_sat from_sm(input logic neg, input logic [MW-1:0] mag);
        t_sat          res;
        logic [MW-1:0] lim;
        lim = neg ? (MW'(1) << (DATA_WIDTH - 1)) : ((MW'(1) << (DATA_WIDTH - 1)) - MW'(1));
        if (mag > lim) begin
            res.ovf = 1'b1;
            res.val = neg ? SMIN : SMAX;
        end else begin
            res.ovf = 1'b0;
            res.val = neg ? DATA_WIDTH'(-mag) : DATA_WIDTH'(mag);
        end
        return res;
    endfunction

    // clamp a one-bit-wider sum
    function automatic t_sat sat_sum(input logic signed [SW-1:0] v);
        t_sat res;
        if (v > SW'(SMAX)) begin
            res.ovf = 1'b1;
            res.val = SMAX;
        end else if (v < SW'(SMIN)) begin
            res.ovf = 1'b1;
            res.val = SMIN;
        end else begin
            res.ovf = 1'b0;
            res.val = v[DATA_WIDTH-1:0];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

### rtl/complex_arith_unit.sv
// top level: front end, word queue and execution back end
// throughput: one word per cycle, every op, while finished results are taken; the back end never iterates
// every word, whatever its op, passes the one-bit-per-stage divider pipeline (data in Q8.8)
// the back end stalls as a whole only while a finished result is not taken
// reset: synchronous active-low i_rst_n empties the queue and all stages
`default_nettype none
module complex_arith_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_real,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_imag,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_real,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_imag,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    output logic [1:0]       o_status
);
    cau_pkg::t_entry entry;
    cau_pkg::t_entry q_data;
    logic            q_valid;
    logic            q_ready;

    cau_front u_front (
        .i_op     (i_op),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_entry  (entry)
    );

    cau_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_valid),
        .o_wr_ready (o_ready),
        .i_wr_data  (entry),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_data)
    );

    cau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_data   (q_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res_real (o_res_real),
        .o_res_imag (o_res_imag),
        .o_status   (o_status)
    );
endmodule
`default_nettype wire

### rtl/cau_front.sv
// front end: classifies the op, forms the sums and all partial products of one word
`default_nettype none
module cau_front (
    input  wire logic [1:0]                      i_op,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_real,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_imag,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_real,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_imag,
    output cau_pkg::t_entry                      o_entry
);
    logic signed [cau_pkg::PW-1:0] sq_r;
    logic signed [cau_pkg::PW-1:0] sq_i;

    always_comb begin
        sq_r = cau_pkg::PW'(i_b_real) * cau_pkg::PW'(i_b_real);
        sq_i = cau_pkg::PW'(i_b_imag) * cau_pkg::PW'(i_b_imag);
        o_entry.op  = i_op;
        o_entry.dz  = (i_op == cau_pkg::OP_DIV) && (i_b_real == '0) && (i_b_imag == '0);
        if (i_op == cau_pkg::OP_SUB) begin
            o_entry.sr = cau_pkg::SW'(i_a_real) - cau_pkg::SW'(i_b_real);
            o_entry.si = cau_pkg::SW'(i_a_imag) - cau_pkg::SW'(i_b_imag);
        end else begin
            o_entry.sr = cau_pkg::SW'(i_a_real) + cau_pkg::SW'(i_b_real);
            o_entry.si = cau_pkg::SW'(i_a_imag) + cau_pkg::SW'(i_b_imag);
        end
        o_entry.prr = cau_pkg::PW'(i_a_real) * cau_pkg::PW'(i_b_real);
        o_entry.pii = cau_pkg::PW'(i_a_imag) * cau_pkg::PW'(i_b_imag);
        o_entry.pri = cau_pkg::PW'(i_a_real) * cau_pkg::PW'(i_b_imag);
        o_entry.pir = cau_pkg::PW'(i_a_imag) * cau_pkg::PW'(i_b_real);
        o_entry.sqr = sq_r[cau_pkg::PW-2:0];
        o_entry.sqi = sq_i[cau_pkg::PW-2:0];
    end
endmodule
`default_nettype wire

### rtl/cau_fifo.sv
// short word queue between front and back
`default_nettype none
module cau_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_valid,
    output logic                 o_wr_ready,
    input  wire cau_pkg::t_entry i_wr_data,
    output logic                 o_rd_valid,
    input  wire logic            i_rd_ready,
    output cau_pkg::t_entry      o_rd_data
);
    cau_pkg::t_entry                r_mem [cau_pkg::FIFO_DEPTH];
    logic [cau_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [cau_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [cau_pkg::FIFO_AW:0]      r_count;
    logic [cau_pkg::FIFO_AW:0]      n_count;
    logic                           push;
    logic                           pop;

    assign o_wr_ready = (r_count != (cau_pkg::FIFO_AW+1)'(cau_pkg::FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push = i_wr_valid && o_wr_ready;
    assign pop  = o_rd_valid && i_rd_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end
endmodule
`default_nettype wire

### rtl/cau_back.sv
// back end: sums, pipelined restoring divider, rounding, saturation, output register
`default_nettype none
module cau_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    output logic                 o_q_ready,
    input  wire cau_pkg::t_entry i_q_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    output logic [1:0]           o_status
);
    typedef struct packed {
        logic [1:0]                    op;
        logic                          dz;
        logic signed [cau_pkg::SW-1:0] sr;
        logic signed [cau_pkg::SW-1:0] si;
        logic signed [cau_pkg::MW-1:0] x;
        logic signed [cau_pkg::MW-1:0] y;
        logic [cau_pkg::PW-1:0]        den;
    } t_s1;

    logic          en;
    t_s1           r_s1;
    logic          r_s1_v;
    t_s1           n_s1;
    cau_pkg::t_ds  n_s2;
    cau_pkg::t_ds  r_ds [cau_pkg::QW+1];
    logic          r_dv [cau_pkg::QW+1];
    logic          r_ov;
    logic signed [cau_pkg::DATA_WIDTH-1:0] r_rr;
    logic signed [cau_pkg::DATA_WIDTH-1:0] r_ri;
    logic [1:0]    r_st;
    logic signed [cau_pkg::DATA_WIDTH-1:0] n_rr;
    logic signed [cau_pkg::DATA_WIDTH-1:0] n_ri;
    logic [1:0]    n_st;

    // one quotient bit per stage, bit taken from the low half of the magnitude
    function automatic cau_pkg::t_ds div_step(input cau_pkg::t_ds s, input int k);
        cau_pkg::t_ds           t;
        logic [cau_pkg::QW-1:0] strm_r;
        logic [cau_pkg::QW-1:0] strm_i;
        logic [cau_pkg::PW:0]   tr;
        logic [cau_pkg::PW:0]   ti;
        t = s;
        strm_r = {s.mr[cau_pkg::DATA_WIDTH-1:0], {(cau_pkg::FRAC_BITS+1){1'b0}}};
        strm_i = {s.mi[cau_pkg::DATA_WIDTH-1:0], {(cau_pkg::FRAC_BITS+1){1'b0}}};
        tr = {s.remr, strm_r[cau_pkg::QW-1-k]};
        ti = {s.remi, strm_i[cau_pkg::QW-1-k]};
        if (tr >= {1'b0, s.den}) begin
            t.remr = cau_pkg::PW'(tr - {1'b0, s.den});
            t.qr   = {s.qr[cau_pkg::QW-2:0], 1'b1};
        end else begin
            t.remr = tr[cau_pkg::PW-1:0];
            t.qr   = {s.qr[cau_pkg::QW-2:0], 1'b0};
        end
        if (ti >= {1'b0, s.den}) begin
            t.remi = cau_pkg::PW'(ti - {1'b0, s.den});
            t.qi   = {s.qi[cau_pkg::QW-2:0], 1'b1};
        end else begin
            t.remi = ti[cau_pkg::PW-1:0];
            t.qi   = {s.qi[cau_pkg::QW-2:0], 1'b0};
        end
        return t;
    endfunction

    // whole pipeline moves together; stalls only when the output word is held
    assign en        = !r_ov || i_ready;
    assign o_q_ready = en;

    always_comb begin
        n_s1.op  = i_q_data.op;
        n_s1.dz  = i_q_data.dz;
        n_s1.sr  = i_q_data.sr;
        n_s1.si  = i_q_data.si;
        if (i_q_data.op == cau_pkg::OP_MUL) begin
            n_s1.x = cau_pkg::MW'(i_q_data.prr) - cau_pkg::MW'(i_q_data.pii);
            n_s1.y = cau_pkg::MW'(i_q_data.pri) + cau_pkg::MW'(i_q_data.pir);
        end else begin
            n_s1.x = cau_pkg::MW'(i_q_data.prr) + cau_pkg::MW'(i_q_data.pii);
            n_s1.y = cau_pkg::MW'(i_q_data.pir) - cau_pkg::MW'(i_q_data.pri);
        end
        n_s1.den = {1'b0, i_q_data.sqr} + {1'b0, i_q_data.sqi};
    end

    always_comb begin
        logic [cau_pkg::MW-1:0] ax;
        logic [cau_pkg::MW-1:0] ay;
        ax = r_s1.x[cau_pkg::MW-1] ? cau_pkg::MW'(-r_s1.x) : cau_pkg::MW'(r_s1.x);
        ay = r_s1.y[cau_pkg::MW-1] ? cau_pkg::MW'(-r_s1.y) : cau_pkg::MW'(r_s1.y);
        n_s2.op   = r_s1.op;
        n_s2.dz   = r_s1.dz;
        n_s2.sr   = r_s1.sr;
        n_s2.si   = r_s1.si;
        n_s2.nr   = r_s1.x[cau_pkg::MW-1];
        n_s2.ni   = r_s1.y[cau_pkg::MW-1];
        n_s2.mr   = ax[cau_pkg::PW-1:0];
        n_s2.mi   = ay[cau_pkg::PW-1:0];
        n_s2.den  = r_s1.den;
        // integer part too large: quotient saturates anyway
        n_s2.capr = {{cau_pkg::DATA_WIDTH{1'b0}}, ax[cau_pkg::PW-1:0]}
                    >= {r_s1.den, {cau_pkg::DATA_WIDTH{1'b0}}};
        n_s2.capi = {{cau_pkg::DATA_WIDTH{1'b0}}, ay[cau_pkg::PW-1:0]}
                    >= {r_s1.den, {cau_pkg::DATA_WIDTH{1'b0}}};
        n_s2.remr = ax[cau_pkg::PW-1:0] >> cau_pkg::DATA_WIDTH;
        n_s2.remi = ay[cau_pkg::PW-1:0] >> cau_pkg::DATA_WIDTH;
        n_s2.qr   = '0;
        n_s2.qi   = '0;
    end

    always_comb begin
        cau_pkg::t_ds           f;
        cau_pkg::t_sat          zr;
        cau_pkg::t_sat          zi;
        logic [cau_pkg::MW-1:0] mr;
        logic [cau_pkg::MW-1:0] mi;
        f = r_ds[cau_pkg::QW];
        mr = '0;
        mi = '0;
        unique case (f.op) inside
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                zr = cau_pkg::sat_sum(f.sr);
                zi = cau_pkg::sat_sum(f.si);
            end
            cau_pkg::OP_MUL: begin
                mr = ({1'b0, f.mr} + cau_pkg::MW'(cau_pkg::HALF)) >> cau_pkg::FRAC_BITS;
                mi = ({1'b0, f.mi} + cau_pkg::MW'(cau_pkg::HALF)) >> cau_pkg::FRAC_BITS;
                zr = cau_pkg::from_sm(f.nr, mr);
                zi = cau_pkg::from_sm(f.ni, mi);
            end
            default: begin
                mr = f.capr ? (cau_pkg::MW'(1) << cau_pkg::DATA_WIDTH)
                            : (cau_pkg::MW'(f.qr) + 1'b1) >> 1;
                mi = f.capi ? (cau_pkg::MW'(1) << cau_pkg::DATA_WIDTH)
                            : (cau_pkg::MW'(f.qi) + 1'b1) >> 1;
                zr = cau_pkg::from_sm(f.nr, mr);
                zi = cau_pkg::from_sm(f.ni, mi);
            end
        endcase
        if (f.dz) begin
            n_rr = '0;
            n_ri = '0;
            n_st = cau_pkg::ST_DZ;
        end else begin
            n_rr = zr.val;
            n_ri = zi.val;
            n_st = (zr.ovf || zi.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_ov   <= 1'b0;
            for (int k = 0; k <= cau_pkg::QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v  <= i_q_valid;
            r_dv[0] <= r_s1_v;
            for (int k = 0; k < cau_pkg::QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ov <= r_dv[cau_pkg::QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= n_s1;
            r_ds[0] <= n_s2;
            for (int k = 0; k < cau_pkg::QW; k++) begin
                r_ds[k+1] <= div_step(r_ds[k], k);
            end
            r_rr <= n_rr;
            r_ri <= n_ri;
            r_st <= n_st;
        end
    end

    assign o_valid    = r_ov;
    assign o_res_real = r_rr;
    assign o_res_imag = r_ri;
    assign o_status   = r_st;
endmodule
`default_nettype wire

### rtl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
`default_nettype none
module cau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [cau_pkg::DATA_WIDTH-1:0] o_res_real,
    input wire logic [cau_pkg::DATA_WIDTH-1:0] o_res_imag,
    input wire logic [1:0]  o_status
);
    // divide by zero always returns zeros
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cau_pkg::ST_DZ |-> o_res_real == '0 && o_res_imag == '0)
        else $error("divide by zero word not zeroed");

    // overflow means at least one part sits on a bound
    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cau_pkg::ST_OVF |->
            o_res_real == cau_pkg::SMAX || o_res_real == cau_pkg::SMIN ||
            o_res_imag == cau_pkg::SMAX || o_res_imag == cau_pkg::SMIN)
        else $error("overflow status without a clamped part");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_real) && $stable(o_res_imag)
            && $stable(o_status))
        else $error("stalled result word changed");
endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_res_real (o_res_real),
    .o_res_imag (o_res_imag),
    .o_status   (o_status)
);
`default_nettype wire

### verif/complex_arith_unit_tb.sv
// self-checking testbench for the complex arithmetic unit
`timescale 1ns / 100ps
`default_nettype none
module complex_arith_unit_tb;
    localparam int N_RANDOM  = 1080;
    localparam int LATENCY   = cau_pkg::DATA_WIDTH + cau_pkg::FRAC_BITS + 4;
    localparam int WDOG_MAX  = 4000;
    localparam int N_DIRECT  = 22;

    typedef logic signed [cau_pkg::DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word      re;
        t_word      im;
        logic [1:0] st;
    } t_cres;

    typedef struct packed {
        logic [1:0] op;
        t_word      ar;
        t_word      ai;
        t_word      br;
        t_word      bi;
        logic       known;  // expected result typed in the row
        t_cres      res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_op = cau_pkg::OP_ADD;
    t_word i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_word o_res_real, o_res_imag;
    logic [1:0] o_status;

    complex_arith_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_res_real(o_res_real), .o_res_imag(o_res_imag), .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cres expected_q[$];
    int    n_errors = 0;
    bit    hold_off = 1'b0;  // long receiver stall requested by the sender
    int    idle_cycles = 0;

    // clamp a signed sign/magnitude value to the output range
    function automatic t_word clamp_sm(input bit neg, input logic [63:0] mag,
                                       inout bit ovf);
        logic [63:0] lim;
        lim = neg ? (64'd1 << (cau_pkg::DATA_WIDTH - 1))
                  : ((64'd1 << (cau_pkg::DATA_WIDTH - 1)) - 1);
        if (mag > lim) begin
            ovf = 1'b1;
            return neg ? cau_pkg::SMIN : cau_pkg::SMAX;
        end
        return neg ? t_word'(-mag) : t_word'(mag);
    endfunction

    function automatic t_word clamp_int(input longint v, inout bit ovf);
        if (v > longint'(cau_pkg::SMAX)) begin
            ovf = 1'b1;
            return cau_pkg::SMAX;
        end
        if (v < longint'(cau_pkg::SMIN)) begin
            ovf = 1'b1;
            return cau_pkg::SMIN;
        end
        return t_word'(v);
    endfunction

    // round(n * 2^FRAC_BITS / d), ties away from zero, capped past range
    function automatic logic [63:0] quotient_mag(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] acc, rem;
        acc = n / d;
        rem = n % d;
        if (acc >= (64'd1 << cau_pkg::DATA_WIDTH)) return 64'd1 << cau_pkg::DATA_WIDTH;
        for (int i = 0; i <= cau_pkg::FRAC_BITS; i++) begin
            rem = rem << 1;
            acc = acc << 1;
            if (rem >= d) begin
                rem = rem - d;
                acc = acc | 64'd1;
            end
        end
        return (acc + 1) >> 1;
    endfunction

    function automatic t_cres complex_result(input logic [1:0] op, input t_word ar,
                                             input t_word ai, input t_word br,
                                             input t_word bi);
        t_cres  r;
        bit     ovf;
        longint pr, pi, den;
        longint half;
        ovf = 1'b0;
        half = (cau_pkg::FRAC_BITS > 0) ? (longint'(1) << (cau_pkg::FRAC_BITS - 1)) : 0;
        r.st = cau_pkg::ST_OK;
        case (op)
            cau_pkg::OP_ADD: begin
                r.re = clamp_int(longint'(ar) + longint'(br), ovf);
                r.im = clamp_int(longint'(ai) + longint'(bi), ovf);
            end
            cau_pkg::OP_SUB: begin
                r.re = clamp_int(longint'(ar) - longint'(br), ovf);
                r.im = clamp_int(longint'(ai) - longint'(bi), ovf);
            end
            cau_pkg::OP_MUL: begin
                pr = longint'(ar) * br - longint'(ai) * bi;
                pi = longint'(ar) * bi + longint'(ai) * br;
                r.re = clamp_sm(pr < 0, ((pr < 0 ? -pr : pr) + half) >> cau_pkg::FRAC_BITS,
                                ovf);
                r.im = clamp_sm(pi < 0, ((pi < 0 ? -pi : pi) + half) >> cau_pkg::FRAC_BITS,
                                ovf);
            end
            default: begin
                if (br == 0 && bi == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = cau_pkg::ST_DZ;
                end else begin
                    den = longint'(br) * br + longint'(bi) * bi;
                    pr = longint'(ar) * br + longint'(ai) * bi;
                    pi = longint'(ai) * br - longint'(ar) * bi;
                    r.re = clamp_sm(pr < 0, quotient_mag(pr < 0 ? -pr : pr, den), ovf);
                    r.im = clamp_sm(pi < 0, quotient_mag(pi < 0 ? -pi : pi, den), ovf);
                end
            end
        endcase
        if (r.st == cau_pkg::ST_OK && ovf) r.st = cau_pkg::ST_OVF;
        return r;
    endfunction

    // operand value biased toward the edges of the range
    function automatic t_word pick_part();
        case ($urandom_range(0, 9)) inside
            0: return cau_pkg::SMAX - t_word'($urandom_range(0, 3));
            1: return cau_pkg::SMIN + t_word'($urandom_range(0, 3));
            2: return t_word'($urandom_range(0, 8)) - 4;
            3, 4: return t_word'(int'($urandom_range(0, 8191)) - 4096);
            default: return t_word'($urandom);
        endcase
    endfunction

    t_row directed [N_DIRECT] = '{
        '{cau_pkg::OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, cau_pkg::ST_OK}},
        '{cau_pkg::OP_ADD, cau_pkg::SMAX, cau_pkg::SMIN, 16'sd1, -16'sd1, 1'b1,
          '{cau_pkg::SMAX, cau_pkg::SMIN, cau_pkg::ST_OVF}},
        '{cau_pkg::OP_ADD, cau_pkg::SMAX, cau_pkg::SMAX, cau_pkg::SMIN, cau_pkg::SMIN,
          1'b1, '{-16'sd1, -16'sd1, cau_pkg::ST_OK}},
        '{cau_pkg::OP_SUB, cau_pkg::SMIN, cau_pkg::SMAX, 16'sd1, -16'sd1, 1'b1,
          '{cau_pkg::SMIN, cau_pkg::SMAX, cau_pkg::ST_OVF}},
        '{cau_pkg::OP_SUB, 16'sd0, 16'sd0, cau_pkg::SMIN, 16'sd0, 1'b1,
          '{cau_pkg::SMAX, 16'sd0, cau_pkg::ST_OVF}},
        '{cau_pkg::OP_SUB, 16'sd5, -16'sd5, 16'sd5, -16'sd5, 1'b1,
          '{16'sd0, 16'sd0, cau_pkg::ST_OK}},
        '{cau_pkg::OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1,
          '{16'sd256, 16'sd0, cau_pkg::ST_OK}},
        '{cau_pkg::OP_MUL, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 1'b1,
          '{-16'sd256, 16'sd0, cau_pkg::ST_OK}},
        '{cau_pkg::OP_MUL, cau_pkg::SMAX, cau_pkg::SMAX, cau_pkg::SMAX, cau_pkg::SMAX,
          1'b0, '0},
        '{cau_pkg::OP_MUL, cau_pkg::SMIN, cau_pkg::SMIN, cau_pkg::SMIN, cau_pkg::SMIN,
          1'b0, '0},
        '{cau_pkg::OP_MUL, cau_pkg::SMIN, 16'sd0, cau_pkg::SMAX, 16'sd0, 1'b0, '0},
        '{cau_pkg::OP_MUL, 16'sd1, 16'sd0, 16'sd128, 16'sd0, 1'b0, '0},
        '{cau_pkg::OP_MUL, -16'sd1, 16'sd0, 16'sd128, 16'sd0, 1'b0, '0},
        '{cau_pkg::OP_MUL, 16'sd3, -16'sd7, 16'sd11, 16'sd13, 1'b0, '0},
        '{cau_pkg::OP_DIV, 16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, cau_pkg::ST_DZ}},
        '{cau_pkg::OP_DIV, cau_pkg::SMAX, cau_pkg::SMIN, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, cau_pkg::ST_DZ}},
        '{cau_pkg::OP_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1,
          '{16'sd256, 16'sd0, cau_pkg::ST_OK}},
        '{cau_pkg::OP_DIV, cau_pkg::SMAX, cau_pkg::SMAX, 16'sd1, 16'sd0, 1'b0, '0},
        '{cau_pkg::OP_DIV, cau_pkg::SMIN, cau_pkg::SMIN, 16'sd1, 16'sd1, 1'b0, '0},
        '{cau_pkg::OP_DIV, 16'sd1, 16'sd0, 16'sd3, 16'sd0, 1'b0, '0},
        '{cau_pkg::OP_DIV, cau_pkg::SMIN, 16'sd77, cau_pkg::SMIN, cau_pkg::SMIN,
          1'b0, '0},
        '{cau_pkg::OP_DIV, -16'sd300, 16'sd500, cau_pkg::SMAX, -16'sd2, 1'b0, '0}
    };

    // one word onto the input channel, waits for acceptance
    task automatic send_word(input logic [1:0] op, input t_word ar, input t_word ai,
                             input t_word br, input t_word bi, input bit known,
                             input t_cres typed);
        t_cres pred;
        pred = complex_result(op, ar, ai, br, bi);
        if (known && pred !== typed) begin
            $display("%0t: table row mismatch exp %h act %h", $time, typed, pred);
            n_errors++;
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(known ? typed : pred);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern plus the long hold-off
    initial begin
        int phase;
        phase = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            phase++;
            if (phase % 256 < 60) i_ready <= 1'b1;
            else i_ready <= (phase % 7 != 0) && ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_cres got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_res_real, o_res_imag, o_status};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.re !== want.re)
                    $display("%0t: res_real exp %h act %h", $time, want.re, got.re);
                if (got.im !== want.im)
                    $display("%0t: res_imag exp %h act %h", $time, want.im, got.im);
                if (got.st !== want.st)
                    $display("%0t: status exp %0d act %0d", $time, want.st, got.st);
                if (got !== want) n_errors++;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int burst;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k])
            send_word(directed[k].op, directed[k].ar, directed[k].ai, directed[k].br,
                      directed[k].bi, directed[k].known, directed[k].res);
        i_valid <= 1'b0;
        @(posedge i_clk);
        drain();
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_off = 1'b1;
            if (n == 600) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                drain();
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            burst--;
            send_word(2'($urandom), pick_part(), pick_part(), pick_part(), pick_part(),
                      1'b0, '0);
        end
        i_valid <= 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
